// ----- rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, codes and default sizes of the block bitmap allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_START = 1'b1;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACHK,
        S_AWR,
        S_FCHK,
        S_FRD,
        S_FWR
    } state_t;

    typedef enum logic {
        R_IDLE,
        R_DONE
    } res_state_t;

endpackage

// ----- rtl/bba_map_mem.sv -----
// ----------------------------------------------------------------------------
// bba_map_mem
// bitmap word memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module bba_map_mem #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bba_word_unit.sv -----
// ----------------------------------------------------------------------------
// bba_word_unit
// full test, lowest clear bit search and bit set or clear on one bitmap word
// ----------------------------------------------------------------------------
module bba_word_unit #(
    parameter int WORD_BITS = 32,
    parameter int BIT_W     = 5
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [BIT_W-1:0]     clr_bit,
    output logic                 full,
    output logic [BIT_W-1:0]     low_bit,
    output logic [WORD_BITS-1:0] word_set,
    output logic [WORD_BITS-1:0] word_clr
);

    logic [WORD_BITS-1:0] low_onehot;

    // lowest clear bit as a one-hot mask
    assign low_onehot = ~word & (word + WORD_BITS'(1));
    assign full       = &word;
    assign word_set   = word | low_onehot;
    assign word_clr   = word & ~(WORD_BITS'(1) << clr_bit);

    always_comb
    begin
        low_bit = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (low_onehot[i])
            begin
                low_bit = low_bit | BIT_W'(i);
            end
        end
    end

endmodule

// ----- rtl/bba_idx_div.sv -----
// ----------------------------------------------------------------------------
// bba_idx_div
// registered split of a block index into bitmap word and bit
// ----------------------------------------------------------------------------
module bba_idx_div #(
    parameter int IDX_W = 13,
    parameter int BIT_W = 5
) (
    input  logic             clk,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    output logic [IDX_W-1:0] quot,
    output logic [BIT_W-1:0] rem
);

    logic [IDX_W-1:0] quot_reg;
    logic [IDX_W-1:0] quot_next;
    logic [BIT_W-1:0] rem_reg;
    logic [BIT_W-1:0] rem_next;

    // word width is a power of two, so the split is a shift and a mask
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            quot_next = dividend >> BIT_W;
            rem_next  = dividend[BIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/block_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// first-fit allocator of data blocks over a bitmap kept in on-chip memory
// ----------------------------------------------------------------------------
// After reset the bitmap memory is swept to zero, one word a cycle, over all
// MAP_WORDS words (128 at the defaults); no request is taken during the
// sweep, register writes are. WORD_BITS must be a power of two. An allocate
// request scans the bitmap words in order through the single read port of
// the bitmap memory and stops on the first word with a clear bit, on a full
// last word or on a word past the data area. A free request does a
// read-modify-write of one bitmap word, skipped when the block lies outside
// the data area. One request is in work at a time; a finished result waits
// in the output register while the next request is taken. Registers are to
// be written only while no request is in work.
module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [31:0] block_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] block_out
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WCNT_W    = $clog2(MAP_WORDS + 1);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = $clog2(MAP_WORDS * WORD_BITS + 1);

    bba_pkg::state_t     state_reg;
    bba_pkg::state_t     state_next;
    bba_pkg::res_state_t res_reg;
    bba_pkg::res_state_t res_next;

    logic [31:0]          total_reg;
    logic [31:0]          start_reg;
    logic [WCNT_W-1:0]    clr_reg;
    logic [WCNT_W-1:0]    clr_next;
    logic [ADDR_W-1:0]    w_reg;
    logic [ADDR_W-1:0]    w_next;
    logic [IDX_W-1:0]     base_reg;
    logic [IDX_W-1:0]     base_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [IDX_W-1:0]     count_reg;
    logic [IDX_W-1:0]     count_next;
    logic [WORD_BITS-1:0] wword_reg;
    logic [WORD_BITS-1:0] wword_next;
    logic [31:0]          blk_reg;
    logic [31:0]          blk_next;
    logic [1:0]           res_status_reg;
    logic [1:0]           res_status_next;
    logic [31:0]          res_block_reg;
    logic [31:0]          res_block_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [31:0]          block_out_reg;
    logic [31:0]          block_out_next;

    logic [31:0]          cfg_diff;
    logic [IDX_W-1:0]     data_count;
    logic [31:0]          free_off;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    logic                 w_full;
    logic [BIT_W-1:0]     w_low_bit;
    logic [WORD_BITS-1:0] w_set;
    logic [WORD_BITS-1:0] w_clr;

    logic                 div_start;
    logic [IDX_W-1:0]     div_quot;
    logic [BIT_W-1:0]     div_rem;

    bba_map_mem #(
        .DEPTH  (MAP_WORDS),
        .WIDTH  (WORD_BITS),
        .ADDR_W (ADDR_W)
    ) u_map_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bba_word_unit #(
        .WORD_BITS (WORD_BITS),
        .BIT_W     (BIT_W)
    ) u_word_unit (
        .word     (rd_data),
        .clr_bit  (div_rem),
        .full     (w_full),
        .low_bit  (w_low_bit),
        .word_set (w_set),
        .word_clr (w_clr)
    );

    bba_idx_div #(
        .IDX_W (IDX_W),
        .BIT_W (BIT_W)
    ) u_idx_div (
        .clk      (clk),
        .start    (div_start),
        .dividend (free_off[IDX_W-1:0]),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            start_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bba_pkg::REG_TOTAL: total_reg <= cfg_data;
                bba_pkg::REG_START: start_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // data block count, saturated to MAX_BLOCKS
    assign cfg_diff = total_reg - start_reg;

    always_comb
    begin
        if (total_reg <= start_reg)
        begin
            data_count = '0;
        end
        else if (cfg_diff > 32'(MAX_BLOCKS))
        begin
            data_count = IDX_W'(MAX_BLOCKS);
        end
        else
        begin
            data_count = cfg_diff[IDX_W-1:0];
        end
    end

    assign free_off = blk_reg - start_reg;

    always_comb
    begin
        state_next      = state_reg;
        res_next        = res_reg;
        clr_next        = clr_reg;
        w_next          = w_reg;
        base_next       = base_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        wword_next      = wword_reg;
        blk_next        = blk_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        status_next     = status_reg;
        block_out_next  = block_out_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        div_start       = 1'b0;

        // finished result moves to the output register when it is free
        if (res_reg == bba_pkg::R_DONE && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            status_next    = res_status_reg;
            block_out_next = res_block_reg;
            res_next       = bba_pkg::R_IDLE;
        end

        case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[ADDR_W-1:0];
                if (clr_reg == WCNT_W'(MAP_WORDS - 1))
                begin
                    state_next = bba_pkg::S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + WCNT_W'(1);
                end
            end
            bba_pkg::S_IDLE:
            begin
                rd_addr = '0;
                if (in_valid && in_ready)
                begin
                    count_next = data_count;
                    blk_next   = block_in;
                    w_next     = '0;
                    base_next  = '0;
                    if (op == bba_pkg::OP_FREE)
                    begin
                        state_next = bba_pkg::S_FCHK;
                    end
                    else
                    begin
                        state_next = bba_pkg::S_ACHK;
                    end
                end
            end
            bba_pkg::S_ACHK:
            begin
                rd_addr = w_reg + ADDR_W'(1);
                if (base_reg >= count_reg)
                begin
                    res_status_next = bba_pkg::ST_NOFREE;
                    res_block_next  = '0;
                    res_next        = bba_pkg::R_DONE;
                    state_next      = bba_pkg::S_IDLE;
                end
                else if (w_full)
                begin
                    if (w_reg == ADDR_W'(MAP_WORDS - 1))
                    begin
                        res_status_next = bba_pkg::ST_NOFREE;
                        res_block_next  = '0;
                        res_next        = bba_pkg::R_DONE;
                        state_next      = bba_pkg::S_IDLE;
                    end
                    else
                    begin
                        w_next    = w_reg + ADDR_W'(1);
                        base_next = base_reg + IDX_W'(WORD_BITS);
                    end
                end
                else
                begin
                    wword_next = w_set;
                    idx_next   = base_reg + IDX_W'(w_low_bit);
                    state_next = bba_pkg::S_AWR;
                end
            end
            bba_pkg::S_AWR:
            begin
                if (idx_reg >= count_reg)
                begin
                    res_status_next = bba_pkg::ST_NOFREE;
                    res_block_next  = '0;
                end
                else
                begin
                    wr_en           = 1'b1;
                    wr_addr         = w_reg;
                    wr_data         = wword_reg;
                    res_status_next = bba_pkg::ST_DONE;
                    res_block_next  = start_reg + 32'(idx_reg);
                end
                res_next   = bba_pkg::R_DONE;
                state_next = bba_pkg::S_IDLE;
            end
            bba_pkg::S_FCHK:
            begin
                if (blk_reg < start_reg || free_off >= 32'(count_reg))
                begin
                    res_status_next = bba_pkg::ST_RANGE;
                    res_block_next  = '0;
                    res_next        = bba_pkg::R_DONE;
                    state_next      = bba_pkg::S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = bba_pkg::S_FRD;
                end
            end
            bba_pkg::S_FRD:
            begin
                rd_addr    = div_quot[ADDR_W-1:0];
                state_next = bba_pkg::S_FWR;
            end
            bba_pkg::S_FWR:
            begin
                wr_en           = 1'b1;
                wr_addr         = div_quot[ADDR_W-1:0];
                wr_data         = w_clr;
                res_status_next = bba_pkg::ST_DONE;
                res_block_next  = '0;
                res_next        = bba_pkg::R_DONE;
                state_next      = bba_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    // a new request waits until the previous result has left the holding stage
    assign in_ready = (state_reg == bba_pkg::S_IDLE) && (res_reg == bba_pkg::R_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::S_CLEAR;
            res_reg       <= bba_pkg::R_IDLE;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        base_reg       <= base_next;
        idx_reg        <= idx_next;
        count_reg      <= count_next;
        wword_reg      <= wword_next;
        blk_reg        <= blk_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        status_reg     <= status_next;
        block_out_reg  <= block_out_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign block_out = block_out_reg;

endmodule

// ----- dv/block_bitmap_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// block_bitmap_allocator_tb
// self-checking bench for the first-fit block bitmap allocator
// ----------------------------------------------------------------------------
module block_bitmap_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_BITS  = bba_pkg::MAX_BLOCKS_DEF;
    localparam int WORD_BITS = bba_pkg::WORD_BITS_DEF;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;

    typedef struct {
        logic        op;
        logic [31:0] blk;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] block;
    } answer_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = bba_pkg::REG_TOTAL;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        op        = bba_pkg::OP_ALLOC;
    logic [31:0] block_in  = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [31:0] block_out;

    // model of the block
    logic [WORD_BITS-1:0] used_map [MAP_WORDS];
    logic [31:0]          area_total = '0;
    logic [31:0]          area_start = '0;

    request_t req_backlog [$];
    answer_t  answer_q [$];
    request_t nxt;
    answer_t  want;
    int       queued_cnt = 0;
    int       taken_cnt  = 0;
    int       errors     = 0;
    int       send_idle  = 23;
    int       recv_idle  = 50;
    int       hold_req   = 0;
    int       hold_cnt   = 0;
    logic     hold_seen  = 1'b0;

    block_bitmap_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .block_in  (block_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .block_out (block_out)
    );

    always #1 clk = ~clk;

    function automatic logic [32:0] area_blocks();
        logic [32:0] n;
        if (area_total <= area_start)
            return '0;
        n = {1'b0, area_total} - {1'b0, area_start};
        if (n > 33'(MAP_BITS))
            n = 33'(MAP_BITS);
        return n;
    endfunction

    function automatic answer_t bitmap_answer(input logic op_i, input logic [31:0] blk);
        answer_t     a;
        logic [32:0] n;
        logic [31:0] idx;
        a.status = bba_pkg::ST_NOFREE;
        a.block  = '0;
        n = area_blocks();
        if (op_i == bba_pkg::OP_ALLOC)
        begin
            if (n == 0)
                return a;
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                if (used_map[w] != '1)
                begin
                    for (int b = 0; b < WORD_BITS; b++)
                    begin
                        if (!used_map[w][b])
                        begin
                            idx = 32'(w * WORD_BITS + b);
                            if ({1'b0, idx} >= n)
                                return a;
                            used_map[w][b] = 1'b1;
                            a.status = bba_pkg::ST_DONE;
                            a.block  = area_start + idx;
                            return a;
                        end
                    end
                end
            end
            return a;
        end
        a.status = bba_pkg::ST_RANGE;
        if (blk < area_start)
            return a;
        idx = blk - area_start;
        if ({1'b0, idx} >= n)
            return a;
        used_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
        a.status = bba_pkg::ST_DONE;
        return a;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                answer_q.push_back(bitmap_answer(op, block_in));
                taken_cnt++;
            end
            if (!in_valid || in_ready)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    nxt = req_backlog.pop_front();
                    in_valid <= 1'b1;
                    op       <= nxt.op;
                    block_in <= nxt.blk;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result receiver with one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cnt != 0)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end
        else if (hold_req != 0 && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_cnt  <= hold_req;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (answer_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d block %h", status, block_out);
            end
            else
            begin
                want = answer_q.pop_front();
                if (status !== want.status || block_out !== want.block)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: status exp %0d got %0d, block exp %h got %h",
                                 want.status, status, want.block, block_out);
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == bba_pkg::REG_TOTAL)
            area_total = val;
        else
            area_start = val;
        @(posedge clk);
    endtask

    task automatic queue_req(input logic o, input logic [31:0] b);
        request_t r;
        r.op  = o;
        r.blk = b;
        req_backlog.push_back(r);
        queued_cnt++;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (taken_cnt != queued_cnt || answer_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input logic [31:0] total, input logic [31:0] start,
                             input int items, input int alloc_pct, input int hold);
        int          r;
        logic [32:0] n;
        logic [31:0] b;
        write_reg(bba_pkg::REG_TOTAL, total);
        write_reg(bba_pkg::REG_START, start);
        n = area_blocks();
        repeat (items)
        begin
            r = $urandom_range(99);
            if (r < alloc_pct)
                queue_req(bba_pkg::OP_ALLOC, $urandom);
            else
            begin
                r = $urandom_range(99);
                if (r < 70 && n != 0)
                    b = start + $urandom_range(n[31:0] - 1);
                else if (r < 80)
                    b = start - 1;
                else if (r < 90)
                    b = start + n[31:0];
                else
                    b = $urandom;
                queue_req(bba_pkg::OP_FREE, b);
            end
        end
        if (hold != 0)
            hold_req <= hold;
        drain();
    endtask

    initial
    begin
        for (int w = 0; w < MAP_WORDS; w++)
            used_map[w] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty area straight out of reset
        queue_req(bba_pkg::OP_ALLOC, 32'h0);
        queue_req(bba_pkg::OP_FREE, 32'h0);
        queue_req(bba_pkg::OP_FREE, 32'hFFFF_FFFF);
        drain();

        // three-block area, filled and run past its end
        write_reg(bba_pkg::REG_TOTAL, 32'd103);
        write_reg(bba_pkg::REG_START, 32'd100);
        queue_req(bba_pkg::OP_ALLOC, 32'hFFFF_FFFF);
        queue_req(bba_pkg::OP_ALLOC, 32'h0);
        queue_req(bba_pkg::OP_ALLOC, 32'h5555_5555);
        queue_req(bba_pkg::OP_ALLOC, 32'hAAAA_AAAA);
        queue_req(bba_pkg::OP_FREE, 32'd101);
        queue_req(bba_pkg::OP_FREE, 32'd101);
        queue_req(bba_pkg::OP_ALLOC, 32'h0);
        queue_req(bba_pkg::OP_FREE, 32'd99);
        queue_req(bba_pkg::OP_FREE, 32'd103);
        queue_req(bba_pkg::OP_FREE, 32'd100);
        queue_req(bba_pkg::OP_ALLOC, 32'h0);
        drain();

        // empty area at the top of the number space
        write_reg(bba_pkg::REG_TOTAL, 32'hFFFF_FFFF);
        write_reg(bba_pkg::REG_START, 32'hFFFF_FFFF);
        queue_req(bba_pkg::OP_ALLOC, 32'h0);
        queue_req(bba_pkg::OP_FREE, 32'hFFFF_FFFF);
        drain();

        // oversized area
        write_reg(bba_pkg::REG_START, 32'h0);
        queue_req(bba_pkg::OP_ALLOC, 32'h0);
        queue_req(bba_pkg::OP_FREE, 32'(MAP_BITS - 1));
        queue_req(bba_pkg::OP_FREE, 32'(MAP_BITS));
        queue_req(bba_pkg::OP_FREE, 32'h8000_0000);
        drain();

        run_phase(32'(MAP_BITS + 64), 32'd64, 200, 70, 0);
        run_phase(32'd1045, 32'd1000, 120, 60, 400);
        send_idle = 50;
        recv_idle = 23;
        run_phase(32'd1040, 32'd1000, 80, 50, 0);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFF0, 80, 50, 0);
        send_idle = 0;
        recv_idle = 0;
        run_phase(32'hFFFF_FFFF, 32'h0, 150, 60, 0);
        run_phase(32'd77, 32'd3, 60, 55, 0);

        repeat (200) @(posedge clk);
        if (answer_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
